[rtl/bdpc_pkg.sv]
// Shared types, constants and codes for the batch dosing pump controller.
`timescale 1ns / 1ps

package bdpc_pkg;

   localparam int VOLUME_BITS  = 20;
   localparam int REPORT_W     = 20;
   localparam int TARGET_W     = 20;
   localparam int TALLY_W      = 16;
   localparam int PHASE_W      = 8;
   localparam int WSTEP_W      = 8;
   localparam int DSTEP_W      = 10;
   localparam int AMOUNT_W     = TALLY_W + WSTEP_W;
   localparam int SUM_W        = ((VOLUME_BITS > AMOUNT_W) ? VOLUME_BITS : AMOUNT_W) + 1;
   localparam int NUM_CH       = 3;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   localparam logic [PHASE_W-1:0]     WINDOW_TICKS = PHASE_W'(101);
   localparam logic [VOLUME_BITS-1:0] VOL_MAX      = {VOLUME_BITS{1'b1}};
   localparam logic [TALLY_W-1:0]     TALLY_MAX    = {TALLY_W{1'b1}};

   localparam logic [WSTEP_W-1:0] WSTEP_RESET  = WSTEP_W'(2);
   localparam logic [DSTEP_W-1:0] DSTEP_A_RESET = DSTEP_W'(15);
   localparam logic [DSTEP_W-1:0] DSTEP_B_RESET = DSTEP_W'(30);

   typedef enum logic [2:0] {
      CMD_WATER_TICK = 3'd0,
      CMD_DOSE_TICK  = 3'd1,
      CMD_FLOW_PULSE = 3'd2,
      CMD_BUTTON     = 3'd3,
      CMD_START_AUTO = 3'd4
   } command_type;

   localparam logic [1:0] CH_WATER  = 2'd0;
   localparam logic [1:0] CH_PUMP_A = 2'd1;
   localparam logic [1:0] CH_PUMP_B = 2'd2;
   localparam logic [1:0] CH_MIX    = 2'd3;

   // Register indexes on the configuration port (byte address / 4)
   localparam logic [1:0] REG_WATER_STEP = 2'd0;
   localparam logic [1:0] REG_DOSE_A     = 2'd1;
   localparam logic [1:0] REG_DOSE_B     = 2'd2;

   typedef struct packed {
      logic [2:0]          command;
      logic [1:0]          channel;
      logic [TARGET_W-1:0] target_volume;
   } req_item_type;

   typedef struct packed {
      logic                water_pump_on;
      logic                pump_a_on;
      logic                pump_b_on;
      logic                mix_pump_on;
      logic [REPORT_W-1:0] water_volume_report;
      logic [REPORT_W-1:0] pump_a_volume_report;
      logic [REPORT_W-1:0] pump_b_volume_report;
   } rsp_item_type;

   typedef struct packed {
      logic [WSTEP_W-1:0] water_step_per_pulse;
      logic [DSTEP_W-1:0] dose_step_a;
      logic [DSTEP_W-1:0] dose_step_b;
   } cfg_type;

endpackage

[rtl/bdpc_csr.sv]
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module bdpc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bdpc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bdpc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bdpc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output bdpc_pkg::cfg_type              cfg
);
   import bdpc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_WATER_STEP: cfg_in.water_step_per_pulse = pwdata[WSTEP_W-1:0];
            REG_DOSE_A:     cfg_in.dose_step_a          = pwdata[DSTEP_W-1:0];
            REG_DOSE_B:     cfg_in.dose_step_b          = pwdata[DSTEP_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_WATER_STEP: prdata = CSR_DATA_W'(cfg_ff.water_step_per_pulse);
         REG_DOSE_A:     prdata = CSR_DATA_W'(cfg_ff.dose_step_a);
         REG_DOSE_B:     prdata = CSR_DATA_W'(cfg_ff.dose_step_b);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.water_step_per_pulse <= WSTEP_RESET;
         cfg_ff.dose_step_a          <= DSTEP_A_RESET;
         cfg_ff.dose_step_b          <= DSTEP_B_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/bdpc_core.sv]
// Controller state and the per-transaction update of flags, timers and volumes.
`timescale 1ns / 1ps

module bdpc_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  bdpc_pkg::req_item_type item,
   input  bdpc_pkg::cfg_type      cfg,
   output bdpc_pkg::rsp_item_type result
);
   import bdpc_pkg::*;

   logic [PHASE_W-1:0]     water_phase_ff, water_phase_in;
   logic [PHASE_W-1:0]     dose_phase_ff, dose_phase_in;
   logic [TALLY_W-1:0]     tally_ff, tally_in;
   logic                   gate_ff, gate_in;
   logic                   timer_en_ff, timer_en_in;
   logic [NUM_CH-1:0]      running_ff, running_in;
   logic [NUM_CH-1:0]      manual_ff, manual_in;
   logic [3:0]             toggle_ff, toggle_in;
   logic [VOLUME_BITS-1:0] volume_ff [NUM_CH];
   logic [VOLUME_BITS-1:0] volume_in [NUM_CH];
   logic [VOLUME_BITS-1:0] target_ff [NUM_CH];
   logic [VOLUME_BITS-1:0] target_in [NUM_CH];
   logic [VOLUME_BITS-1:0] snap_ff   [NUM_CH];
   logic [VOLUME_BITS-1:0] snap_in   [NUM_CH];

   logic [AMOUNT_W-1:0]    amount  [NUM_CH];
   logic [SUM_W-1:0]       sum     [NUM_CH];
   logic [VOLUME_BITS-1:0] sat     [NUM_CH];
   logic [NUM_CH-1:0]      over;
   logic [NUM_CH-1:0]      check_en;
   logic [PHASE_W-1:0]     water_next_phase;
   logic [PHASE_W-1:0]     dose_next_phase;
   logic                   press_on;

   // Window additions for each channel; a water tick applies the water one, a dose tick the dose ones.
   always_comb begin
      amount[0] = AMOUNT_W'(tally_ff) * AMOUNT_W'(cfg.water_step_per_pulse);
      amount[1] = AMOUNT_W'(cfg.dose_step_a);
      amount[2] = AMOUNT_W'(cfg.dose_step_b);
      for (int i = 0; i < NUM_CH; i++) begin
         sum[i]  = SUM_W'(volume_ff[i]) + SUM_W'(amount[i]);
         sat[i]  = (sum[i] > SUM_W'(VOL_MAX)) ? VOL_MAX : sum[i][VOLUME_BITS-1:0];
         over[i] = (sat[i] > target_ff[i]) && !manual_ff[i];
      end
   end

   always_comb begin
      water_phase_in   = water_phase_ff;
      dose_phase_in    = dose_phase_ff;
      tally_in         = tally_ff;
      gate_in          = gate_ff;
      timer_en_in      = timer_en_ff;
      running_in       = running_ff;
      manual_in        = manual_ff;
      toggle_in        = toggle_ff;
      volume_in        = volume_ff;
      target_in        = target_ff;
      snap_in          = snap_ff;
      check_en         = '0;
      water_next_phase = water_phase_ff + PHASE_W'(1);
      dose_next_phase  = dose_phase_ff + PHASE_W'(1);
      press_on         = !toggle_ff[item.channel];

      case (item.command)
         CMD_WATER_TICK: begin
            if (timer_en_ff) begin
               water_phase_in = water_next_phase;
               if (running_ff[0]) begin
                  if (water_next_phase != '0 && water_next_phase < WINDOW_TICKS) begin
                     gate_in = 1'b1;
                  end else if (water_next_phase == WINDOW_TICKS) begin
                     gate_in        = 1'b0;
                     check_en[0]    = 1'b1;
                     tally_in       = '0;
                     water_phase_in = '0;
                  end
               end
            end
         end
         CMD_DOSE_TICK: begin
            dose_phase_in = dose_next_phase;
            if (dose_next_phase == WINDOW_TICKS) begin
               check_en[1]   = running_ff[1];
               check_en[2]   = running_ff[2];
               dose_phase_in = '0;
            end
         end
         CMD_FLOW_PULSE: begin
            if (gate_ff && tally_ff != TALLY_MAX) begin
               tally_in = tally_ff + TALLY_W'(1);
            end
         end
         CMD_BUTTON: begin
            toggle_in[item.channel] = press_on;
            if (item.channel == CH_MIX) begin
               tally_in = '0;
            end else begin
               running_in[item.channel] = press_on;
               manual_in[item.channel]  = press_on;
               if (!press_on) begin
                  volume_in[item.channel] = '0;
                  target_in[item.channel] = '0;
               end
               if (item.channel == CH_WATER) begin
                  timer_en_in = press_on;
                  if (!press_on) begin
                     gate_in  = 1'b0;
                     tally_in = '0;
                  end
               end
            end
         end
         CMD_START_AUTO: begin
            if (item.channel != CH_MIX) begin
               target_in[item.channel]  = VOLUME_BITS'(item.target_volume);
               running_in[item.channel] = 1'b1;
               if (item.channel == CH_WATER) begin
                  timer_en_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      // Apply the window addition; an auto-mode overshoot stops and clears.
      for (int i = 0; i < NUM_CH; i++) begin
         if (check_en[i]) begin
            snap_in[i] = sat[i];
            if (over[i]) begin
               running_in[i] = 1'b0;
               volume_in[i]  = '0;
            end else begin
               volume_in[i] = sat[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         water_phase_ff <= '0;
         dose_phase_ff  <= '0;
         tally_ff       <= '0;
         gate_ff        <= 1'b0;
         timer_en_ff    <= 1'b0;
         running_ff     <= '0;
         manual_ff      <= '0;
         toggle_ff      <= '0;
         for (int i = 0; i < NUM_CH; i++) begin
            volume_ff[i] <= '0;
            target_ff[i] <= '0;
            snap_ff[i]   <= '0;
         end
      end else if (en) begin
         water_phase_ff <= water_phase_in;
         dose_phase_ff  <= dose_phase_in;
         tally_ff       <= tally_in;
         gate_ff        <= gate_in;
         timer_en_ff    <= timer_en_in;
         running_ff     <= running_in;
         manual_ff      <= manual_in;
         toggle_ff      <= toggle_in;
         volume_ff      <= volume_in;
         target_ff      <= target_in;
         snap_ff        <= snap_in;
      end
   end

   // Result reflects the state after this transaction.
   always_comb begin
      result.water_pump_on        = running_in[0];
      result.pump_a_on            = running_in[1];
      result.pump_b_on            = running_in[2];
      result.mix_pump_on          = toggle_in[3];
      result.water_volume_report  = REPORT_W'(snap_in[0]);
      result.pump_a_volume_report = REPORT_W'(snap_in[1]);
      result.pump_b_volume_report = REPORT_W'(snap_in[2]);
   end

endmodule

[rtl/batch_dosing_pump_controller.sv]
// Top level: input register, controller core, result register and configuration port.
`timescale 1ns / 1ps

// Batch dosing pump controller.
// Request channel (req_valid / req_stall / req_item) carries one command per
// transaction: water tick, dose tick, flow pulse, button press or start auto.
// Every accepted command yields exactly one response transaction on
// rsp_valid / rsp_stall / rsp_item with the pump drive flags and the last
// volume snapshots as they stand after that command.
// The command is held in the input register and is computed by the core into
// the result register, which drives rsp_valid and rsp_item.
// Throughput: one command per cycle while the receiver does not hold rsp_stall;
// the core update is a single pass of one 16x8 multiply, a saturating add and a target compare.
// When the receiver holds rsp_stall, the response holds and one more command
// waits in the input register; req_stall then rises until the response drains.
// Reset (synchronous, active high) clears all flags, timers, tallies and
// volumes and loads the step registers with 2, 15 and 30.
// Step registers are written over the APB-style port at byte addresses 0, 4
// and 8; write them only while no command is in flight.

module batch_dosing_pump_controller (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  bdpc_pkg::req_item_type         req_item,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output bdpc_pkg::rsp_item_type         rsp_item,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bdpc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bdpc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bdpc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import bdpc_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type core_result;
   cfg_type      cfg;
   logic         advance;
   logic         req_take;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   bdpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bdpc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .en     (in_valid_ff && advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (in_valid_ff && advance) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
